[rtl/art_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Retransmission tracker package
// Shared sizes, codes and the word carried between table cells.
// ---------------------------------------------------------------------------
package art_pkg;

   localparam int TableDepth    = 16;
   localparam int IdxWidth      = $clog2(TableDepth);
   localparam int CntWidth      = $clog2(TableDepth + 1);
   localparam logic [7:0] FastThreshold = 8'd3;
   localparam logic [15:0] MinTimeout   = 16'd50;
   localparam logic [7:0] LaterAckMax   = 8'd255;

   localparam logic [1:0] FUNC_EXPECT = 2'd0;
   localparam logic [1:0] FUNC_ACK    = 2'd1;
   localparam logic [1:0] FUNC_CHECK  = 2'd2;

   localparam logic [1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_RETRY   = 2'd1;
   localparam logic [1:0] CSR_FAST    = 2'd2;

   localparam logic [2:0] KIND_STORED    = 3'd0;
   localparam logic [2:0] KIND_FULL      = 3'd1;
   localparam logic [2:0] KIND_ACKED     = 3'd2;
   localparam logic [2:0] KIND_UNMATCHED = 3'd3;
   localparam logic [2:0] KIND_RETRY     = 3'd4;
   localparam logic [2:0] KIND_DROP      = 3'd5;
   localparam logic [2:0] KIND_NONE_DUE  = 3'd6;

   typedef struct packed {
      logic        valid;
      logic [31:0] id;
      logic [7:0]  channel;
      logic [31:0] sent_time;
      logic [7:0]  retries;
      logic [7:0]  later_acks;
   } entry_type;

endpackage
`default_nettype wire

[rtl/art_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Retransmission tracker cell
// One table slot. On rotate it loads the word presented at its input.
// ---------------------------------------------------------------------------
module art_cell
   import art_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      rotate,
   input  wire entry_type word_in,
   output entry_type      word_out
);

   entry_type word_ff;
   entry_type word_in_w;

   always_comb begin
      word_in_w = word_ff;
      if (rotate) begin
         word_in_w = word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else begin
         word_ff.valid <= word_in_w.valid;
      end
      word_ff.id         <= word_in_w.id;
      word_ff.channel    <= word_in_w.channel;
      word_ff.sent_time  <= word_in_w.sent_time;
      word_ff.retries    <= word_in_w.retries;
      word_ff.later_acks <= word_in_w.later_acks;
   end

   assign word_out = word_ff;

endmodule
`default_nettype wire

[rtl/ack_retransmit_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Retransmission tracker
// Ordered table of unacknowledged packets held in a ring of cells.
// ---------------------------------------------------------------------------
// An expect is answered the cycle after it is taken, and the next word can follow at once
// unless the result port stalls. An ack or a check holds the block through a scan of the
// ring, tail steps that close each hole left by removals and a done step for its final word.
// The words rotate once through the cell ring, one cell a cycle, newest first; a stalled
// result port holds the scan. Retry and drop words leave during the scan, each held until
// the next due entry, the last as the final word. Synchronous reset empties the table.
module ack_retransmit_tracker
   import art_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [31:0] req_packet_id,
   input  wire logic [7:0]  req_channel,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_kind,
   output logic [31:0]      rsp_out_packet_id,
   output logic [7:0]       rsp_out_channel,
   output logic [31:0]      rsp_rtt_ms,
   output logic             rsp_last,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_TAIL = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [15:0] timeout_ff;
   logic [7:0]  retry_limit_ff;
   logic        fast_ff;

   logic [1:0]  func_ff;
   logic [31:0] pid_ff, now_ff;
   logic [IdxWidth-1:0] step_ff, step_in;
   logic        found_ff, found_in;
   logic [31:0] rtt_ff, rtt_in;

   logic        pend_valid_ff, pend_valid_in;
   logic [2:0]  pend_kind_ff, pend_kind_in;
   logic [31:0] pend_id_ff, pend_id_in;
   logic [7:0]  pend_ch_ff, pend_ch_in;

   logic        rsp_valid_ff;
   logic [2:0]  kind_ff;
   logic [31:0] opid_ff, rtt_out_ff;
   logic [7:0]  och_ff;
   logic        last_ff;

   entry_type cell_out [TableDepth];
   entry_type cell_in  [TableDepth];
   entry_type head, head_new, new_word;
   logic rotate;
   logic emit;
   logic [2:0]  emit_kind;
   logic [31:0] emit_id;
   logic [7:0]  emit_ch;
   logic [31:0] emit_rtt;
   logic        emit_last;
   logic out_free;
   logic full;
   logic fast_due, time_due;
   logic gap;
   logic [TableDepth-1:0] hole_below;

   // Cell 0 holds the oldest word. A scan rotates the ring upward so the top cell
   // is seen first and, after TableDepth steps, every word is back in its cell.
   assign full = cell_out[TableDepth-1].valid;
   assign head = cell_out[TableDepth-1];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;

   always_comb begin
      new_word.valid      = 1'b1;
      new_word.id         = req_packet_id;
      new_word.channel    = req_channel;
      new_word.sent_time  = req_now_ms;
      new_word.retries    = '0;
      new_word.later_acks = '0;
   end

   always_comb begin
      fast_due = fast_ff && (head.later_acks >= FastThreshold);
      time_due = (now_ff - head.sent_time) >= {16'd0, timeout_ff};
      hole_below[0] = !cell_out[0].valid;
      gap = 1'b0;
      for (int i = 1; i < TableDepth; i++) begin
         hole_below[i] = hole_below[i-1] || !cell_out[i].valid;
         if (!cell_out[i-1].valid && cell_out[i].valid) begin
            gap = 1'b1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      found_in      = found_ff;
      rtt_in        = rtt_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_id_in    = pend_id_ff;
      pend_ch_in    = pend_ch_ff;
      rotate        = 1'b0;
      emit          = 1'b0;
      emit_kind     = KIND_NONE_DUE;
      emit_id       = '0;
      emit_ch       = '0;
      emit_rtt      = '0;
      emit_last     = 1'b0;
      head_new      = head;
      for (int i = 0; i < TableDepth; i++) begin
         cell_in[i] = cell_out[i];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_func == FUNC_EXPECT) begin
                  emit      = 1'b1;
                  emit_kind = full ? KIND_FULL : KIND_STORED;
                  emit_id   = req_packet_id;
                  emit_last = 1'b1;
                  if (!full) begin
                     rotate = 1'b1;
                     if (!cell_out[0].valid) begin
                        cell_in[0] = new_word;
                     end
                     for (int i = 1; i < TableDepth; i++) begin
                        if (!cell_out[i].valid && cell_out[i-1].valid) begin
                           cell_in[i] = new_word;
                        end
                     end
                  end
               end else if (req_func == FUNC_ACK || req_func == FUNC_CHECK) begin
                  state_in      = ST_SCAN;
                  step_in       = '0;
                  found_in      = 1'b0;
                  rtt_in        = '0;
                  pend_valid_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               rotate = 1'b1;
               if (head.valid) begin
                  if (func_ff == FUNC_ACK) begin
                     if (fast_ff && head.id < pid_ff && head.later_acks != LaterAckMax) begin
                        head_new.later_acks = head.later_acks + 8'd1;
                     end
                     if (head.id == pid_ff) begin
                        head_new.valid = 1'b0;
                        if (!found_ff) begin
                           found_in = 1'b1;
                           rtt_in = now_ff - head.sent_time;
                        end
                     end
                  end else if (fast_due || time_due) begin
                     if (pend_valid_ff) begin
                        emit      = 1'b1;
                        emit_kind = pend_kind_ff;
                        emit_id   = pend_id_ff;
                        emit_ch   = pend_ch_ff;
                     end
                     pend_valid_in = 1'b1;
                     pend_id_in    = head.id;
                     pend_ch_in    = head.channel;
                     if (head.retries >= retry_limit_ff) begin
                        pend_kind_in   = KIND_DROP;
                        head_new.valid = 1'b0;
                     end else begin
                        pend_kind_in        = KIND_RETRY;
                        head_new.retries    = head.retries + 8'd1;
                        head_new.sent_time  = now_ff;
                        head_new.later_acks = '0;
                     end
                  end
               end
               cell_in[0] = head_new;
               for (int i = 1; i < TableDepth; i++) begin
                  cell_in[i] = cell_out[i-1];
               end
               step_in = step_ff + IdxWidth'(1);
               if (step_ff == IdxWidth'(TableDepth - 1)) begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_TAIL: begin
            // Each cycle closes the lowest hole by moving every word above it down.
            if (gap) begin
               rotate = 1'b1;
               for (int i = 0; i < TableDepth - 1; i++) begin
                  if (hole_below[i]) begin
                     cell_in[i] = cell_out[i+1];
                  end
               end
               if (hole_below[TableDepth-1]) begin
                  cell_in[TableDepth-1].valid = 1'b0;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               emit          = 1'b1;
               emit_last     = 1'b1;
               state_in      = ST_IDLE;
               pend_valid_in = 1'b0;
               if (func_ff == FUNC_ACK) begin
                  emit_id = pid_ff;
                  if (found_ff) begin
                     emit_kind = KIND_ACKED;
                     emit_rtt  = rtt_ff;
                  end else begin
                     emit_kind = KIND_UNMATCHED;
                  end
               end else if (pend_valid_ff) begin
                  emit_kind = pend_kind_ff;
                  emit_id   = pend_id_ff;
                  emit_ch   = pend_ch_ff;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   for (genvar g = 0; g < TableDepth; g++) begin : g_cell
      art_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .rotate   (rotate),
         .word_in  (cell_in[g]),
         .word_out (cell_out[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         timeout_ff     <= 16'd1000;
         retry_limit_ff <= 8'd3;
         fast_ff        <= 1'b1;
         rsp_valid_ff   <= 1'b0;
         step_ff        <= '0;
         found_ff       <= 1'b0;
         pend_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_TIMEOUT: timeout_ff <= (csr_write_data < MinTimeout)
                                          ? MinTimeout : csr_write_data;
               CSR_RETRY:   retry_limit_ff <= csr_write_data[7:0];
               CSR_FAST:    fast_ff <= csr_write_data[0];
               default: ;
            endcase
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      rtt_ff       <= rtt_in;
      pend_kind_ff <= pend_kind_in;
      pend_id_ff   <= pend_id_in;
      pend_ch_ff   <= pend_ch_in;
      if (req_valid && req_ready) begin
         func_ff <= req_func;
         pid_ff  <= req_packet_id;
         now_ff  <= req_now_ms;
      end
      if (emit) begin
         kind_ff    <= emit_kind;
         opid_ff    <= emit_id;
         och_ff     <= emit_ch;
         rtt_out_ff <= emit_rtt;
         last_ff    <= emit_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_out_packet_id = opid_ff;
   assign rsp_out_channel   = och_ff;
   assign rsp_rtt_ms        = rtt_out_ff;
   assign rsp_last          = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_packet_id) && $stable(rsp_kind))
      else $error("result word changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("input taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register corrupt");

endmodule
`default_nettype wire
